/* sv/sum_checked_frame_receiver_defines.svh */
// Assertion macros for the sum-checked frame receiver.
// Included by the top level; uses its i_clk and i_rst_n.
`ifndef SUM_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define SUM_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define SCFR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("scfr check failed");

// Implication checked at every clock edge out of reset
`define SCFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scfr check failed");

`endif

/* sv/scfr_pkg.sv */
// Shared types and constants of the sum-checked frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LENGTH  = 8'd7;

    // Frame classification codes
    localparam logic [2:0] KIND_ANSWER = 3'd0;
    localparam logic [2:0] KIND_REPORT = 3'd1;
    localparam logic [2:0] KIND_ERROR  = 3'd2;
    localparam logic [2:0] KIND_OTHER  = 3'd3;
    localparam logic [2:0] KIND_BADSUM = 3'd4;
    localparam logic [2:0] KIND_SHORT  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANSWER = 2'd0;
    localparam logic [1:0] CFG_REPORT = 2'd1;
    localparam logic [1:0] CFG_ERROR  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] ANSWER_RESET = 8'd2;
    localparam logic [7:0] REPORT_RESET = 8'd3;
    localparam logic [7:0] ERROR_RESET  = 8'd4;

    // Parsed frame handed from the parser to the classifier
    typedef struct packed {
        logic        short_frame;
        logic        sum_ok;
        logic [7:0]  command;
        logic [7:0]  func;
        logic [31:0] data;
    } t_frame_rec;

    // Command codes in use
    typedef struct packed {
        logic [7:0] answer;
        logic [7:0] report;
        logic [7:0] error;
    } t_codes;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/sum_checked_frame_receiver.sv */
// Sum-checked frame receiver: one received byte per cycle, one result per frame.
// A frame result enters the queue at the edge that takes the checksum byte (or a
// short length byte) and moves on into the output register once that is free or taken.
// Throughput: one byte per cycle; input stalls only while two frame results wait
// in the queue and fill it.
// Reset (synchronous, active low) restarts the header hunt, empties the queue and
// restores the command codes to 2, 3 and 4.
`timescale 1ns / 1ps
`include "sum_checked_frame_receiver_defines.svh"

module sum_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_kind,
    output logic [7:0]  o_command_byte,
    output logic [7:0]  o_function_byte,
    output logic [31:0] o_data_word
);

    scfr_pkg::t_codes     r_codes;
    scfr_pkg::t_frame_rec w_front_rec, w_q_rec;
    scfr_pkg::t_q_status  w_q_status;
    logic                 w_take, w_push, w_pop;

    // Hold off the link while the queue is full
    assign o_stall = w_q_status.full;
    assign w_take  = i_valid && !o_stall;

    // Write command code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.answer <= scfr_pkg::ANSWER_RESET;
            r_codes.report <= scfr_pkg::REPORT_RESET;
            r_codes.error  <= scfr_pkg::ERROR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scfr_pkg::CFG_ANSWER: r_codes.answer <= i_cfg_data;
                scfr_pkg::CFG_REPORT: r_codes.report <= i_cfg_data;
                scfr_pkg::CFG_ERROR:  r_codes.error  <= i_cfg_data;
                default:              r_codes        <= r_codes;
            endcase
        end
    end

    scfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_rx_byte),
        .o_push  (w_push),
        .o_rec   (w_front_rec)
    );

    scfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_rec    (w_front_rec),
        .i_pop    (w_pop),
        .o_rec    (w_q_rec),
        .o_status (w_q_status)
    );

    scfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_codes         (r_codes),
        .i_q_empty       (w_q_status.empty),
        .i_rec           (w_q_rec),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_kind    (o_frame_kind),
        .o_command_byte  (o_command_byte),
        .o_function_byte (o_function_byte),
        .o_data_word     (o_data_word)
    );

    // Checks
    `SCFR_ASSERT_ALWAYS(a_q_full_empty, !(w_q_status.full && w_q_status.empty))
    `SCFR_ASSERT_IMPL(a_push_room, w_push, !w_q_status.full)
    `SCFR_ASSERT_IMPL(a_rise_from_queue, $rose(o_valid), $past(!w_q_status.empty))
    `SCFR_ASSERT_IMPL(a_pop_nonempty, w_pop, !w_q_status.empty)

endmodule

/* sv/scfr_front.sv */
// Byte parser: header hunt, length, running sum and field capture.
// Depends on scfr_pkg; pushes one frame record per finished frame.
`timescale 1ns / 1ps

module scfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output scfr_pkg::t_frame_rec o_rec
);

    typedef enum logic [1:0] {
        S_HUNT1,
        S_HUNT2,
        S_LEN,
        S_BODY
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_position, n_position;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_fun, n_fun;
    logic [31:0] r_data, n_data;
    logic [7:0]  w_pos_inc;

    assign w_pos_inc = r_position + 8'd1;

    // Parse one byte per accepted transaction
    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_position  = r_position;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        n_fun       = r_fun;
        n_data      = r_data;
        o_push      = 1'b0;
        o_rec       = '{short_frame: 1'b0, sum_ok: (i_byte == r_sum),
                        command: r_cmd, func: r_fun, data: r_data};
        if (i_take) begin
            case (r_state)
                S_HUNT1: begin
                    if (i_byte == scfr_pkg::HEADER_BYTE) n_state = S_HUNT2;
                end
                S_HUNT2: begin
                    n_state = (i_byte == scfr_pkg::HEADER_BYTE) ? S_LEN : S_HUNT1;
                end
                S_LEN: begin
                    n_remaining = i_byte;
                    n_position  = 8'd0;
                    n_sum       = i_byte;
                    n_cmd       = 8'd0;
                    n_fun       = 8'd0;
                    n_data      = 32'd0;
                    if (i_byte < scfr_pkg::MIN_LENGTH) begin
                        // too short: report at once and resume the hunt
                        n_state     = S_HUNT1;
                        n_remaining = 8'd0;
                        o_push      = 1'b1;
                        o_rec       = '{short_frame: 1'b1, sum_ok: 1'b0,
                                        command: 8'd0, func: 8'd0, data: 32'd0};
                    end else begin
                        n_state = S_BODY;
                    end
                end
                S_BODY: begin
                    n_position = w_pos_inc;
                    if (r_remaining <= 8'd1) begin
                        // checksum byte closes the frame
                        n_remaining = 8'd0;
                        n_state     = S_HUNT1;
                        o_push      = 1'b1;
                    end else begin
                        n_remaining = r_remaining - 8'd1;
                        n_sum       = r_sum + i_byte;
                        case (w_pos_inc)
                            8'd1:    n_cmd          = i_byte;
                            8'd2:    n_fun          = i_byte;
                            8'd3:    n_data[7:0]    = i_byte;
                            8'd4:    n_data[15:8]   = i_byte;
                            8'd5:    n_data[23:16]  = i_byte;
                            8'd6:    n_data[31:24]  = i_byte;
                            default: n_data         = r_data;
                        endcase
                    end
                end
                default: n_state = S_HUNT1;
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT1;
            r_remaining <= 8'd0;
            r_position  <= 8'd0;
            r_sum       <= 8'd0;
            r_cmd       <= 8'd0;
            r_fun       <= 8'd0;
            r_data      <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_position  <= n_position;
            r_sum       <= n_sum;
            r_cmd       <= n_cmd;
            r_fun       <= n_fun;
            r_data      <= n_data;
        end
    end

endmodule

/* sv/scfr_queue.sv */
// Two-entry queue of frame records between parser and classifier.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  scfr_pkg::t_frame_rec  i_rec,
    input  logic                  i_pop,
    output scfr_pkg::t_frame_rec  o_rec,
    output scfr_pkg::t_q_status   o_status
);

    scfr_pkg::t_frame_rec r_mem [2];
    logic                 r_wr_ptr, r_rd_ptr;
    logic [1:0]           r_count;
    logic                 w_push, w_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_rec          = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_rec;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/scfr_back.sv */
// Classifier: turns a frame record into a result in the output register.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scfr_pkg::t_codes     i_codes,
    input  logic                 i_q_empty,
    input  scfr_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_frame_kind,
    output logic [7:0]           o_command_byte,
    output logic [7:0]           o_function_byte,
    output logic [31:0]          o_data_word
);

    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_cmd, r_fun;
    logic [31:0] r_data;
    logic [2:0] w_kind;

    // Load the output register when it is empty or being taken
    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    // Classify; answer beats report beats error
    always_comb begin
        if (i_rec.short_frame)                       w_kind = scfr_pkg::KIND_SHORT;
        else if (!i_rec.sum_ok)                      w_kind = scfr_pkg::KIND_BADSUM;
        else if (i_rec.command == i_codes.answer)    w_kind = scfr_pkg::KIND_ANSWER;
        else if (i_rec.command == i_codes.report)    w_kind = scfr_pkg::KIND_REPORT;
        else if (i_rec.command == i_codes.error)     w_kind = scfr_pkg::KIND_ERROR;
        else                                         w_kind = scfr_pkg::KIND_OTHER;
    end

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= w_kind;
            r_cmd  <= i_rec.command;
            r_fun  <= i_rec.func;
            r_data <= i_rec.data;
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_kind    = r_kind;
    assign o_command_byte  = r_cmd;
    assign o_function_byte = r_fun;
    assign o_data_word     = r_data;

endmodule

/* tb/frame_result_checker.sv */
// Checker for the sum-checked frame receiver: mirrors the command codes, predicts
// the frame results from the accepted bytes and compares them with the results.
// Depends on scfr_pkg for the classification codes and register indexes.
`timescale 1ns / 1ps

module frame_result_checker
    import scfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_frame_kind,
    input  logic [7:0]  i_command_byte,
    input  logic [7:0]  i_function_byte,
    input  logic [31:0] i_data_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        IN_BODY
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  command;
        logic [7:0]  func;
        logic [31:0] data;
    } frame_result_t;

    // Mirrored command codes
    logic [7:0] answer_cd;
    logic [7:0] report_cd;
    logic [7:0] error_cd;

    // Parser state
    parse_phase_t parse_phase;
    logic [7:0]   bytes_left;
    logic [7:0]   body_pos;
    logic [7:0]   sum_acc;
    logic [7:0]   cmd_hold;
    logic [7:0]   fun_hold;
    logic [31:0]  data_hold;

    frame_result_t frame_results_q[$];
    int            fails = 0;
    int            checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Advance the parser by one received byte; return 1 when it closes a frame
    function automatic logic parse_rx_byte(input logic [7:0] b, output frame_result_t res);
        logic emitted;
        emitted = 1'b0;
        res     = '0;
        case (parse_phase)
            HUNT_FIRST: begin
                if (b == HEADER_BYTE) parse_phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                parse_phase = (b == HEADER_BYTE) ? TAKE_LENGTH : HUNT_FIRST;
            end
            TAKE_LENGTH: begin
                bytes_left = b;
                body_pos   = 8'd0;
                sum_acc    = b;
                cmd_hold   = 8'd0;
                fun_hold   = 8'd0;
                data_hold  = 32'd0;
                if (b < MIN_LENGTH) begin
                    // too short: report at once, resume the hunt with the next byte
                    parse_phase = HUNT_FIRST;
                    bytes_left  = 8'd0;
                    res.kind    = KIND_SHORT;
                    emitted     = 1'b1;
                end else begin
                    parse_phase = IN_BODY;
                end
            end
            IN_BODY: begin
                body_pos = body_pos + 8'd1;
                if (bytes_left <= 8'd1) begin
                    // checksum byte closes the frame
                    bytes_left  = 8'd0;
                    parse_phase = HUNT_FIRST;
                    if (b != sum_acc)              res.kind = KIND_BADSUM;
                    else if (cmd_hold == answer_cd) res.kind = KIND_ANSWER;
                    else if (cmd_hold == report_cd) res.kind = KIND_REPORT;
                    else if (cmd_hold == error_cd)  res.kind = KIND_ERROR;
                    else                            res.kind = KIND_OTHER;
                    res.command = cmd_hold;
                    res.func    = fun_hold;
                    res.data    = data_hold;
                    emitted     = 1'b1;
                end else begin
                    bytes_left = bytes_left - 8'd1;
                    sum_acc    = sum_acc + b;
                    if (body_pos == 8'd1) cmd_hold = b;
                    else if (body_pos == 8'd2) fun_hold = b;
                    else if (body_pos >= 8'd3 && body_pos <= 8'd6)
                        data_hold[8 * (body_pos - 3) +: 8] = b;
                end
            end
        endcase
        return emitted;
    endfunction

    // Watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        frame_result_t got;
        frame_result_t exp_res;
        frame_result_t fresh;
        if (!i_rst_n) begin
            answer_cd   = ANSWER_RESET;
            report_cd   = REPORT_RESET;
            error_cd    = ERROR_RESET;
            parse_phase = HUNT_FIRST;
            bytes_left  = 8'd0;
            body_pos    = 8'd0;
            sum_acc     = 8'd0;
            cmd_hold    = 8'd0;
            fun_hold    = 8'd0;
            data_hold   = 32'd0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ANSWER: answer_cd = i_cfg_data;
                    CFG_REPORT: report_cd = i_cfg_data;
                    CFG_ERROR:  error_cd  = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare a delivered result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got.kind    = i_frame_kind;
                got.command = i_command_byte;
                got.func    = i_function_byte;
                got.data    = i_data_word;
                if (frame_results_q.size() == 0) begin
                    $error("unexpected frame result: kind %0d command %02h", got.kind,
                           got.command);
                    fails++;
                end else begin
                    exp_res = frame_results_q.pop_front();
                    checked++;
                    if (got.kind !== exp_res.kind) begin
                        $error("frame_kind: expected %0d, actual %0d", exp_res.kind, got.kind);
                        fails++;
                    end
                    if (got.command !== exp_res.command) begin
                        $error("command_byte: expected %02h, actual %02h", exp_res.command,
                               got.command);
                        fails++;
                    end
                    if (got.func !== exp_res.func) begin
                        $error("function_byte: expected %02h, actual %02h", exp_res.func,
                               got.func);
                        fails++;
                    end
                    if (got.data !== exp_res.data) begin
                        $error("data_word: expected %08h, actual %08h", exp_res.data,
                               got.data);
                        fails++;
                    end
                end
            end

            // Predict from the accepted byte
            if (i_in_valid && !i_in_stall) begin
                if (parse_rx_byte(i_rx_byte, fresh)) frame_results_q.push_back(fresh);
            end
        end
        o_pending    <= frame_results_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

/* tb/sum_checked_frame_receiver_tb.sv */
// Testbench top for the sum-checked frame receiver: drives byte streams of framed,
// short, broken and noisy traffic under several command code settings.
// Depends on scfr_pkg, sum_checked_frame_receiver and frame_result_checker.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_tb;
    import scfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SEGMENT_BYTES  = 420;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_idx      = CFG_ANSWER;
    logic [7:0]  cfg_data     = 8'd0;
    logic        rx_valid     = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte      = 8'd0;
    logic        res_valid;
    logic        res_stall    = 1'b0;
    logic [2:0]  frame_kind;
    logic [7:0]  command_byte;
    logic [7:0]  function_byte;
    logic [31:0] data_word;

    int          fail_count;
    int          pending;
    int          checked;
    int          tx_gap_pct   = 8;
    int          rx_stall_pct = 45;
    int          sent_bytes   = 0;
    int          quiet_cycles = 0;

    // Command codes currently programmed
    logic [7:0]  answer_cd    = ANSWER_RESET;
    logic [7:0]  report_cd    = REPORT_RESET;
    logic [7:0]  error_cd     = ERROR_RESET;

    sum_checked_frame_receiver i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (rx_valid),
        .o_stall        (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_frame_kind   (frame_kind),
        .o_command_byte (command_byte),
        .o_function_byte(function_byte),
        .o_data_word    (data_word)
    );

    frame_result_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (rx_valid),
        .i_in_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .i_frame_kind   (frame_kind),
        .i_command_byte (command_byte),
        .i_function_byte(function_byte),
        .i_data_word    (data_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk) begin
        res_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((rx_valid && !rx_stall) || (res_valid && !res_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, with random gaps ahead of it, and hold it until taken
    task automatic send_rx_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        sent_bytes++;
    endtask

    // Header, length and, for a legal length, the body with its checksum
    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input logic [7:0] fun, input logic [31:0] data,
                              input bit sum_ok);
        logic [7:0] body[$];
        logic [7:0] sum;
        sum = len;
        send_rx_byte(HEADER_BYTE);
        send_rx_byte(HEADER_BYTE);
        send_rx_byte(len);
        if (len < MIN_LENGTH) return;
        body.push_back(cmd);
        body.push_back(fun);
        for (int i = 0; i < 4; i++) body.push_back(data[8 * i +: 8]);
        for (int i = 7; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
        foreach (body[i]) begin
            sum = sum + body[i];
            send_rx_byte(body[i]);
        end
        send_rx_byte(sum_ok ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    // Write all three codes on consecutive edges
    task automatic set_codes(input logic [7:0] ans, input logic [7:0] rep,
                             input logic [7:0] err);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ANSWER;
        cfg_data <= ans;
        @(posedge clk);
        cfg_idx  <= CFG_REPORT;
        cfg_data <= rep;
        @(posedge clk);
        cfg_idx  <= CFG_ERROR;
        cfg_data <= err;
        @(posedge clk);
        cfg_we   <= 1'b0;
        answer_cd = ans;
        report_cd = rep;
        error_cd  = err;
    endtask

    // Drop valid and let every frame result come out
    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 3))
            0:       return answer_cd;
            1:       return report_cd;
            2:       return error_cd;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames, plus short frames, noise and broken headers
    task automatic send_random_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        int         sub;
        logic [7:0] len;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                sub = $urandom_range(0, 99);
                if (sub < 65)      len = MIN_LENGTH;
                else if (sub < 93) len = 8'($urandom_range(8, 12));
                else if (sub < 99) len = 8'($urandom_range(13, 40));
                else               len = 8'($urandom_range(200, 255));
                send_frame(len, pick_command(), 8'($urandom_range(0, 255)), $urandom(),
                           $urandom_range(0, 99) < 85);
            end else if (pick < 82) begin
                send_frame(8'($urandom_range(0, 6)), 8'd0, 8'd0, 32'd0, 1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 3) == 0) send_rx_byte(HEADER_BYTE);
                    else send_rx_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 99) begin
                send_rx_byte(HEADER_BYTE);
                send_rx_byte(8'($urandom_range(0, 254)));
            end else begin
                // a third header byte is taken as the length
                send_frame(HEADER_BYTE, pick_command(), 8'($urandom_range(0, 255)),
                           $urandom(), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: broken header, zero length, answer with all-ones data,
        // long frame with a bad checksum, plain report frame
        send_rx_byte(HEADER_BYTE);
        send_rx_byte(8'h00);
        send_frame(8'd0, 8'd0, 8'd0, 32'd0, 1'b1);
        send_frame(MIN_LENGTH, ANSWER_RESET, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_frame(8'd8, REPORT_RESET, 8'hFF, 32'h0000_0000, 1'b0);
        send_frame(MIN_LENGTH, REPORT_RESET, 8'h5A, 32'h1234_5678, 1'b1);

        wait_idle();
        set_codes(8'h00, 8'hFF, 8'h80);
        send_random_traffic(SEGMENT_BYTES);

        wait_idle();
        tx_gap_pct   = 45;
        rx_stall_pct = 8;
        set_codes(8'h55, 8'h55, 8'h55);
        send_random_traffic(SEGMENT_BYTES);

        wait_idle();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        set_codes(8'hFF, 8'h10, 8'h10);
        send_random_traffic(SEGMENT_BYTES);

        wait_idle();
        $display("Summary: %0d bytes sent, %0d frame results checked", sent_bytes, checked);
        $display("Four command code settings, three idling modes");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
